// ===== hw/rtl/fxalu_pkg.sv =====
// fxalu_pkg: shared types and opcodes for the q24.8 fixed-point alu
// no dependencies
package fxalu_pkg;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_MIN  = 4'd4,
        OP_MAX  = 4'd5,
        OP_INC  = 4'd6,
        OP_DEC  = 4'd7,
        OP_ITOF = 4'd8,
        OP_FTOI = 4'd9
    } op_t;

    typedef struct packed {
        logic [3:0]         op;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               a_less;
        logic               a_equal;
        logic               a_greater;
        logic               div_by_zero;
    } out_beat_t;

    // classified item passed from front to back
    typedef struct packed {
        logic [3:0]         op;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic               lt;
        logic               eq;
        logic               is_div;
        logic               dz;
    } cls_t;

endpackage

// ===== hw/rtl/fxalu_front.sv =====
// fxalu_front: accepts input beats, compares operands, registers the class
// depends on fxalu_pkg
module fxalu_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  fxalu_pkg::in_beat_t  in_beat,
    output logic                 cls_valid,
    input  logic                 cls_ready,
    output fxalu_pkg::cls_t      cls
);

    logic            valid_reg;
    fxalu_pkg::cls_t data_reg;
    fxalu_pkg::cls_t data_next;

    assign full      = valid_reg && !cls_ready;
    assign cls_valid = valid_reg;
    assign cls       = data_reg;

    always_comb
    begin
        data_next.op     = in_beat.op;
        data_next.a      = in_beat.operand_a;
        data_next.b      = in_beat.operand_b;
        data_next.lt     = in_beat.operand_a < in_beat.operand_b;
        data_next.eq     = in_beat.operand_a == in_beat.operand_b;
        data_next.is_div = in_beat.op == fxalu_pkg::OP_DIV;
        data_next.dz     = in_beat.operand_b == 32'sd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!full)
        begin
            valid_reg <= push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== hw/rtl/fxalu_back.sv =====
// fxalu_back: pipelined execution (multiplier, radix-2 divider) and result queue
// depends on fxalu_pkg
module fxalu_back #(
    parameter int FRAC_BITS = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cls_valid,
    output logic                 cls_ready,
    input  fxalu_pkg::cls_t      cls,
    output logic                 empty,
    input  logic                 pop,
    output fxalu_pkg::out_beat_t out_beat
);

    localparam int DW     = 32 + FRAC_BITS;     // dividend width
    localparam int STAGES = DW;                 // one quotient bit per stage
    localparam int DEPTH  = STAGES + 4;         // covers every beat in flight
    localparam int AW     = $clog2(DEPTH);

    typedef struct packed {
        logic               v;
        fxalu_pkg::cls_t    c;
        logic signed [31:0] val;
        logic               neg;
        logic [DW-1:0]      rem;
        logic [DW-1:0]      quo;
        logic [31:0]        dvs;
    } stg_t;

    stg_t pipe_reg [STAGES+1];
    stg_t pipe_next [STAGES+1];

    logic [AW:0]   used_reg;
    logic [AW:0]   used_next;
    logic [AW:0]   mcnt_reg;
    logic [AW:0]   mcnt_next;
    logic [AW-1:0] wr_reg;
    logic [AW-1:0] rd_reg;
    fxalu_pkg::out_beat_t mem [DEPTH];
    fxalu_pkg::out_beat_t res;
    fxalu_pkg::out_beat_t out_reg;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          take;
    logic          do_pop;
    logic          fin;
    logic          out_free;
    logic          from_mem;
    logic          bypass;
    logic          wr_en;

    // credit: beats taken and not yet popped never exceed the queue
    assign cls_ready = used_reg < (AW+1)'(DEPTH);
    assign take      = cls_valid && cls_ready;
    assign used_next = used_reg + {{AW{1'b0}}, take} - {{AW{1'b0}}, do_pop};

    // stage 0: simple ops, product, divider setup; then one quotient bit per stage
    logic signed [63:0] prod;
    logic [DW-1:0]      mag_a;
    logic [31:0]        mag_b;
    logic [DW:0]        trial [STAGES];

    always_comb
    begin
        prod  = 64'(cls.a) * 64'(cls.b);
        mag_a = DW'(cls.a[31] ? -{{FRAC_BITS{cls.a[31]}}, cls.a} : {{FRAC_BITS{1'b0}}, cls.a})
                << FRAC_BITS;
        mag_b = cls.b[31] ? 32'(-cls.b) : 32'(cls.b);
        pipe_next[0]     = '0;
        pipe_next[0].v   = take;
        pipe_next[0].c   = cls;
        pipe_next[0].neg = cls.a[31] ^ cls.b[31];
        pipe_next[0].rem = '0;
        pipe_next[0].quo = mag_a;
        pipe_next[0].dvs = mag_b;
        case (cls.op)
            fxalu_pkg::OP_ADD:  pipe_next[0].val = cls.a + cls.b;
            fxalu_pkg::OP_SUB:  pipe_next[0].val = cls.a - cls.b;
            fxalu_pkg::OP_MUL:  pipe_next[0].val = 32'(prod >>> FRAC_BITS);
            fxalu_pkg::OP_MIN:  pipe_next[0].val = cls.lt ? cls.a : cls.b;
            fxalu_pkg::OP_MAX:  pipe_next[0].val = (!cls.lt && !cls.eq) ? cls.a : cls.b;
            fxalu_pkg::OP_INC:  pipe_next[0].val = cls.a + 32'sd1;
            fxalu_pkg::OP_DEC:  pipe_next[0].val = cls.a - 32'sd1;
            fxalu_pkg::OP_ITOF: pipe_next[0].val = cls.a <<< FRAC_BITS;
            fxalu_pkg::OP_FTOI: pipe_next[0].val = cls.a >>> FRAC_BITS;
            default:            pipe_next[0].val = '0;
        endcase
        // restoring divide
        for (int i = 1; i <= STAGES; i++)
        begin
            pipe_next[i] = pipe_reg[i-1];
            trial[i-1] = {pipe_reg[i-1].rem, pipe_reg[i-1].quo[DW-1]}
                         - {{(DW-31){1'b0}}, pipe_reg[i-1].dvs};
            if (!trial[i-1][DW])
            begin
                pipe_next[i].rem = trial[i-1][DW-1:0];
                pipe_next[i].quo = {pipe_reg[i-1].quo[DW-2:0], 1'b1};
            end
            else
            begin
                pipe_next[i].rem = {pipe_reg[i-1].rem[DW-2:0], pipe_reg[i-1].quo[DW-1]};
                pipe_next[i].quo = {pipe_reg[i-1].quo[DW-2:0], 1'b0};
            end
        end
    end

    // final result assembly
    logic [DW-1:0] q_s;
    always_comb
    begin
        q_s = pipe_reg[STAGES].neg ? -pipe_reg[STAGES].quo : pipe_reg[STAGES].quo;
        res.a_less      = pipe_reg[STAGES].c.lt;
        res.a_equal     = pipe_reg[STAGES].c.eq;
        res.a_greater   = !pipe_reg[STAGES].c.lt && !pipe_reg[STAGES].c.eq;
        res.div_by_zero = pipe_reg[STAGES].c.is_div && pipe_reg[STAGES].c.dz;
        if (pipe_reg[STAGES].c.is_div)
        begin
            res.value = pipe_reg[STAGES].c.dz ? 32'sd0 : q_s[31:0];
        end
        else
        begin
            res.value = pipe_reg[STAGES].val;
        end
    end

    // output register in front of the queue memory; an empty memory is bypassed
    assign fin            = pipe_reg[STAGES].v;
    assign empty          = !out_valid_reg;
    assign do_pop         = pop && out_valid_reg;
    assign out_free       = !out_valid_reg || do_pop;
    assign from_mem       = out_free && (mcnt_reg != '0);
    assign bypass         = out_free && (mcnt_reg == '0) && fin;
    assign wr_en          = fin && !bypass;
    assign out_valid_next = from_mem || bypass || (out_valid_reg && !do_pop);
    assign mcnt_next      = mcnt_reg + {{AW{1'b0}}, wr_en} - {{AW{1'b0}}, from_mem};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= STAGES; i++)
            begin
                pipe_reg[i] <= '0;
            end
            used_reg      <= '0;
            mcnt_reg      <= '0;
            wr_reg        <= '0;
            rd_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i <= STAGES; i++)
            begin
                pipe_reg[i] <= pipe_next[i];
            end
            used_reg      <= used_next;
            mcnt_reg      <= mcnt_next;
            out_valid_reg <= out_valid_next;
            if (wr_en)
            begin
                wr_reg <= (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (from_mem)
            begin
                rd_reg <= (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_reg] <= res;
        end
        if (from_mem)
        begin
            out_reg <= mem[rd_reg];
        end
        else if (bypass)
        begin
            out_reg <= res;
        end
    end

    assign out_beat = out_reg;

endmodule

// ===== hw/rtl/fixed_point_q24_8_alu_core.sv =====
// channel   dir   handshake       payload
// in        in    push / full     fxalu_pkg::in_beat_t  (op, operand_a, operand_b)
// result    out   pop / empty     fxalu_pkg::out_beat_t (value, flags, div_by_zero)
//
// one beat per cycle sustained while results are popped; every beat walks the
// radix-2 divider pipeline (one quotient bit per stage), whatever its op.
// the front register holds the classified beat; the back reserves queue slots
// for all beats in flight, so a stalled pop only back-pressures via full.
// rst_n clears control state asynchronously; nothing needs a clearing pass.
module fixed_point_q24_8_alu_core #(
    parameter int FRAC_BITS = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  fxalu_pkg::in_beat_t  in_beat,
    output logic                 empty,
    input  logic                 pop,
    output fxalu_pkg::out_beat_t out_beat
);

    logic            cls_valid;
    logic            cls_ready;
    fxalu_pkg::cls_t cls;

    fxalu_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_beat   (in_beat),
        .cls_valid (cls_valid),
        .cls_ready (cls_ready),
        .cls       (cls)
    );

    fxalu_back #(.FRAC_BITS(FRAC_BITS)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cls_valid (cls_valid),
        .cls_ready (cls_ready),
        .cls       (cls),
        .empty     (empty),
        .pop       (pop),
        .out_beat  (out_beat)
    );

endmodule

// ===== tb/tb_fixed_point_q24_8_alu_core.sv =====
// tb_fixed_point_q24_8_alu_core: self-checking testbench for the q24.8 fixed-point alu
// depends on fxalu_pkg and fixed_point_q24_8_alu_core; predicts every result beat
`timescale 1ns / 1ps

module tb_fixed_point_q24_8_alu_core;

    localparam int FRAC = 8;
    localparam int LATENCY = 34 + FRAC;

    logic                 clk;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    fxalu_pkg::in_beat_t  in_beat;
    logic                 empty;
    logic                 pop;
    fxalu_pkg::out_beat_t out_beat;

    fixed_point_q24_8_alu_core #(.FRAC_BITS(FRAC)) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_beat  (in_beat),
        .empty    (empty),
        .pop      (pop),
        .out_beat (out_beat)
    );

    fxalu_pkg::out_beat_t pending_results[$];
    int        errors;
    int        send_idle_pct;
    int        recv_stall_pct;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic fxalu_pkg::out_beat_t alu_result(fxalu_pkg::in_beat_t beat);
        fxalu_pkg::out_beat_t r;
        logic signed [63:0] prod;
        logic signed [63:0] num;
        logic signed [63:0] quo;
        r = '0;
        r.a_less    = (beat.operand_a < beat.operand_b);
        r.a_equal   = (beat.operand_a == beat.operand_b);
        r.a_greater = (beat.operand_a > beat.operand_b);
        case (beat.op)
            fxalu_pkg::OP_ADD:  r.value = beat.operand_a + beat.operand_b;
            fxalu_pkg::OP_SUB:  r.value = beat.operand_a - beat.operand_b;
            fxalu_pkg::OP_MUL:
            begin
                prod = 64'(beat.operand_a) * 64'(beat.operand_b);
                r.value = 32'(prod >>> FRAC);
            end
            fxalu_pkg::OP_DIV:
            begin
                if (beat.operand_b == 0)
                begin
                    r.div_by_zero = 1'b1;
                    r.value = '0;
                end
                else
                begin
                    num = 64'(beat.operand_a) <<< FRAC;
                    quo = num / 64'(beat.operand_b);
                    r.value = 32'(quo);
                end
            end
            fxalu_pkg::OP_MIN:  r.value = (beat.operand_a < beat.operand_b) ? beat.operand_a
                                                                            : beat.operand_b;
            fxalu_pkg::OP_MAX:  r.value = (beat.operand_a > beat.operand_b) ? beat.operand_a
                                                                            : beat.operand_b;
            fxalu_pkg::OP_INC:  r.value = beat.operand_a + 32'sd1;
            fxalu_pkg::OP_DEC:  r.value = beat.operand_a - 32'sd1;
            fxalu_pkg::OP_ITOF: r.value = beat.operand_a <<< FRAC;
            fxalu_pkg::OP_FTOI: r.value = beat.operand_a >>> FRAC;
            default:            r.value = '0;
        endcase
        return r;
    endfunction

    // directed table; expected value typed in where obvious
    typedef struct {
        logic [3:0]  op;
        logic [31:0] a;
        logic [31:0] b;
        bit          typed;
        logic [31:0] value;
        logic [3:0]  flags;
    } vec_t;

    localparam logic [31:0] MAXP = 32'h7fffffff;
    localparam logic [31:0] MINN = 32'h80000000;

    vec_t vectors[] = '{
        '{fxalu_pkg::OP_ADD,  MAXP, 32'd1, 1, MINN, 4'b0010},
        '{fxalu_pkg::OP_SUB,  MINN, 32'd1, 1, MAXP, 4'b1000},
        '{fxalu_pkg::OP_ADD,  32'hffffffff, 32'hffffffff, 1, 32'hfffffffe, 4'b0100},
        '{fxalu_pkg::OP_MUL,  32'h00000100, 32'h00000100, 1, 32'h00000100, 4'b0100},
        '{fxalu_pkg::OP_MUL,  MINN, MINN, 0, 0, 0},
        '{fxalu_pkg::OP_MUL,  MAXP, MINN, 0, 0, 0},
        '{fxalu_pkg::OP_MUL,  32'hffffffff, 32'd1, 1, 32'hffffffff, 4'b1000},
        '{fxalu_pkg::OP_DIV,  32'd5, 32'd0, 1, 32'd0, 4'b0011},
        '{fxalu_pkg::OP_DIV,  MINN, 32'd0, 1, 32'd0, 4'b1001},
        '{fxalu_pkg::OP_DIV,  MINN, 32'hffffffff, 0, 0, 0},
        '{fxalu_pkg::OP_DIV,  MAXP, 32'd1, 0, 0, 0},
        '{fxalu_pkg::OP_DIV,  32'hfffffff9, 32'd2, 0, 0, 0},
        '{fxalu_pkg::OP_DIV,  32'h00000100, 32'h00000200, 1, 32'h00000080, 4'b1000},
        '{fxalu_pkg::OP_MIN,  MINN, MAXP, 1, MINN, 4'b1000},
        '{fxalu_pkg::OP_MAX,  MINN, MAXP, 1, MAXP, 4'b1000},
        '{fxalu_pkg::OP_MIN,  32'd7, 32'd7, 1, 32'd7, 4'b0100},
        '{fxalu_pkg::OP_INC,  MAXP, 32'd0, 1, MINN, 4'b0010},
        '{fxalu_pkg::OP_DEC,  MINN, 32'd0, 1, MAXP, 4'b1000},
        '{fxalu_pkg::OP_ITOF, 32'h00800000, 32'd0, 1, MINN, 4'b0010},
        '{fxalu_pkg::OP_ITOF, 32'hffffffff, 32'hffffffff, 1, 32'hffffff00, 4'b0100},
        '{fxalu_pkg::OP_FTOI, MINN, 32'd0, 1, 32'hff800000, 4'b1000},
        '{fxalu_pkg::OP_FTOI, 32'hffffffff, 32'd0, 1, 32'hffffffff, 4'b1000},
        '{4'd10,   32'd1, 32'd2, 1, 32'd0, 4'b1000},
        '{4'd15,   MAXP, MINN, 1, 32'd0, 4'b0010}
    };

    // leaves push high after the beat is taken; the caller or the next idle drops it
    task automatic send_beat(fxalu_pkg::in_beat_t beat, bit typed,
                             fxalu_pkg::out_beat_t typed_res);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        in_beat <= beat;
        pending_results.push_back(typed ? typed_res : alu_result(beat));
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(5))
            0: return MAXP;
            1: return MINN;
            2: return 32'($urandom_range(8)) - 32'd4;
            3: return 32'($signed(16'($urandom)));
            default: return $urandom;
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // receiver side
    always @(posedge clk)
    begin
        fxalu_pkg::out_beat_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result beat expected none actual %h", $time, out_beat);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (out_beat.value !== want.value)
                    begin
                        $display("%0t: value expected %h actual %h", $time,
                                 want.value, out_beat.value);
                        errors++;
                    end
                    if ({out_beat.a_less, out_beat.a_equal, out_beat.a_greater}
                        !== {want.a_less, want.a_equal, want.a_greater})
                    begin
                        $display("%0t: compare flags expected %b%b%b actual %b%b%b",
                                 $time, want.a_less, want.a_equal, want.a_greater,
                                 out_beat.a_less, out_beat.a_equal, out_beat.a_greater);
                        errors++;
                    end
                    if (out_beat.div_by_zero !== want.div_by_zero)
                    begin
                        $display("%0t: div_by_zero expected %b actual %b", $time,
                                 want.div_by_zero, out_beat.div_by_zero);
                        errors++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        fxalu_pkg::in_beat_t  beat;
        fxalu_pkg::out_beat_t typed_res;
        int        phase_idle[4];
        int        phase_stall[4];
        phase_idle  = '{0, 65, 0, 9};
        phase_stall = '{0, 0, 65, 9};
        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n   = 1'b0;
        push    = 1'b0;
        pop     = 1'b0;
        in_beat = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (vectors[i])
        begin
            beat.op        = vectors[i].op;
            beat.operand_a = vectors[i].a;
            beat.operand_b = vectors[i].b;
            typed_res.value       = vectors[i].value;
            {typed_res.a_less, typed_res.a_equal, typed_res.a_greater,
             typed_res.div_by_zero} = vectors[i].flags;
            send_beat(beat, vectors[i].typed, typed_res);
        end

        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = phase_idle[p];
            recv_stall_pct = phase_stall[p];
            for (int n = 0; n < 132; n++)
            begin
                beat.op = ($urandom_range(15) == 0) ? 4'($urandom_range(15, 10))
                                                    : 4'($urandom_range(9));
                beat.operand_a = rand_operand();
                beat.operand_b = ($urandom_range(9) == 0) ? beat.operand_a
                                                          : rand_operand();
                send_beat(beat, 0, typed_res);
                // hold off once until the pipe drains
                if (p == 1 && n == 60)
                begin
                    push <= 1'b0;
                    wait_drained();
                end
            end
        end

        push <= 1'b0;
        recv_stall_pct = 0;
        wait_drained();
        repeat (LATENCY * 2) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("fixed_point_q24_8_alu_core verification clean");
        else
            $display("fixed_point_q24_8_alu_core verification failed");
        $finish;
    end

    initial
    begin
        #400000;
        $display("fixed_point_q24_8_alu_core verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/fxalu_pkg.sv
hw/rtl/fxalu_front.sv
hw/rtl/fxalu_back.sv
hw/rtl/fixed_point_q24_8_alu_core.sv
tb/tb_fixed_point_q24_8_alu_core.sv
